>>> hw/rtl/load_cell_peak_capture_macros.svh
// ----------------------------------------------------------------------------
// Load cell peak capture assertion macros
// Concurrent assertion helpers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef LOAD_CELL_PEAK_CAPTURE_MACROS_SVH
`define LOAD_CELL_PEAK_CAPTURE_MACROS_SVH

`ifndef SYNTHESIS

// Checks that cond holds at every clock edge outside reset.
`define LCPC_ASSERT(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("load_cell_peak_capture assertion failed");

// Checks that cons holds in the cycle after ante.
`define LCPC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load_cell_peak_capture assertion failed");

`else

`define LCPC_ASSERT(label, clk, rst_n, cond)
`define LCPC_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> hw/rtl/lcpc_pkg.sv
// ----------------------------------------------------------------------------
// Load cell peak capture package
// Widths, codes and shared types of the load cell peak capture block.
// ----------------------------------------------------------------------------
package lcpc_pkg;

    // Converter word width and derived arithmetic widths.
    localparam int SAMPLE_BITS = 24;
    localparam int RAW_BITS    = 24;
    localparam int FORCE_BITS  = 24;
    localparam int GAIN_BITS   = 24;
    localparam int GAIN_SHIFT  = 16;
    localparam int THR_BITS    = 16;
    localparam int THR_SHIFT   = 8;
    localparam int COUNT_BITS  = 10;
    localparam int DIFF_BITS   = (SAMPLE_BITS > RAW_BITS) ? SAMPLE_BITS : RAW_BITS;
    localparam int PROD_BITS   = DIFF_BITS + GAIN_BITS;

    localparam logic [DIFF_BITS-1:0] SAMPLE_MASK =
        DIFF_BITS'((64'd1 << SAMPLE_BITS) - 64'd1);
    localparam logic [DIFF_BITS-1:0] SIGN_MASK =
        DIFF_BITS'(64'd1 << (SAMPLE_BITS - 1));

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 24;

    localparam logic [FORCE_BITS-1:0] TARE_RESET  = 24'd0;
    localparam logic [GAIN_BITS-1:0]  GAIN_RESET  = 24'd38992;
    localparam logic [THR_BITS-1:0]   START_RESET = 16'd100;
    localparam logic [THR_BITS-1:0]   STOP_RESET  = 16'd20;
    localparam logic [COUNT_BITS-1:0] MAX_RESET   = 10'd100;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_TARE_OFFSET     = 3'd0,
        REG_GAIN_Q24        = 3'd1,
        REG_START_THRESHOLD = 3'd2,
        REG_STOP_THRESHOLD  = 3'd3,
        REG_MAX_SAMPLES     = 3'd4
    } lcpc_reg_t;

    typedef enum logic [1:0] {
        MODE_SAMPLE = 2'd0,
        MODE_ARM    = 2'd1,
        MODE_ABORT  = 2'd2
    } lcpc_mode_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_CAPT = 2'd2
    } lcpc_phase_t;

    typedef struct packed {
        logic [FORCE_BITS-1:0] tare_offset;
        logic [GAIN_BITS-1:0]  gain_q24;
    } lcpc_scale_cfg_t;

    typedef struct packed {
        logic [1:0]            mode;
        logic [FORCE_BITS-1:0] force_q8;
    } lcpc_scaled_t;

    typedef struct packed {
        logic [FORCE_BITS-1:0] force_q8;
        logic [1:0]            phase;
        logic                  done_res;
        logic                  aborted;
        logic [FORCE_BITS-1:0] peak_q8;
        logic [COUNT_BITS-1:0] sample_count;
    } lcpc_result_t;

endpackage

>>> hw/rtl/lcpc_ifs.sv
// ----------------------------------------------------------------------------
// Load cell peak capture channels
// Valid/ready channels for samples, results and register writes.
// ----------------------------------------------------------------------------
interface lcpc_item_if
    import lcpc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [1:0]          mode;
    logic [RAW_BITS-1:0] raw_sample;

    modport source (output valid, output mode, output raw_sample, input ready);
    modport sink (input valid, input mode, input raw_sample, output ready);
endinterface

interface lcpc_result_if
    import lcpc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [FORCE_BITS-1:0] force_q8;
    logic [1:0]            phase;
    logic                  done_res;
    logic                  aborted;
    logic [FORCE_BITS-1:0] peak_q8;
    logic [COUNT_BITS-1:0] sample_count;

    modport source (output valid, output force_q8, output phase, output done_res,
                    output aborted, output peak_q8, output sample_count, input ready);
    modport sink (input valid, input force_q8, input phase, input done_res,
                  input aborted, input peak_q8, input sample_count, output ready);
endinterface

interface lcpc_cfg_if
    import lcpc_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [CFG_DATA_BITS-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> hw/rtl/lcpc_scaler.sv
// ----------------------------------------------------------------------------
// Load cell force scaler
// Two-stage pipeline: tare-corrected magnitude, then gain multiply and saturate.
// ----------------------------------------------------------------------------
module lcpc_scaler
    import lcpc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  lcpc_scale_cfg_t     cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          in_mode,
    input  logic [RAW_BITS-1:0] in_raw,
    output logic                out_valid,
    input  logic                out_ready,
    output lcpc_scaled_t        out_item
);

    logic                 s1_valid_reg;
    logic [1:0]           s1_mode_reg;
    logic [DIFF_BITS-1:0] s1_diff_reg;
    logic                 s2_valid_reg;
    lcpc_scaled_t         s2_item_reg;

    logic                 s1_load;
    logic                 s2_load;
    logic [DIFF_BITS-1:0] offset_bin;
    logic [DIFF_BITS-1:0] tare_ext;
    logic [DIFF_BITS-1:0] diff_next;
    logic [PROD_BITS-1:0] product;
    logic [FORCE_BITS-1:0] force_next;

    // A stage takes new data when it is empty or its content moves on.
    assign s2_load  = s1_valid_reg && (!s2_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s2_load;
    assign s1_load  = in_valid && in_ready;

    // Sign flip turns two's complement into offset binary.
    assign offset_bin = (DIFF_BITS'(in_raw) & SAMPLE_MASK) ^ SIGN_MASK;
    assign tare_ext   = DIFF_BITS'(cfg.tare_offset);
    assign diff_next  = (offset_bin >= tare_ext) ? (offset_bin - tare_ext)
                                                 : (tare_ext - offset_bin);

    assign product = PROD_BITS'(s1_diff_reg) * PROD_BITS'(cfg.gain_q24);

    always_comb
    begin
        if (|product[PROD_BITS-1:GAIN_SHIFT+FORCE_BITS])
        begin
            force_next = '1;
        end
        else
        begin
            force_next = product[GAIN_SHIFT+FORCE_BITS-1:GAIN_SHIFT];
        end
        if (s1_mode_reg != MODE_SAMPLE)
        begin
            force_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (!s2_valid_reg || out_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_mode_reg <= in_mode;
            s1_diff_reg <= diff_next;
        end
        if (s2_load)
        begin
            s2_item_reg.mode     <= s1_mode_reg;
            s2_item_reg.force_q8 <= force_next;
        end
    end

    assign out_valid = s2_valid_reg;
    assign out_item  = s2_item_reg;

endmodule

>>> hw/rtl/load_cell_peak_capture.sv
// ----------------------------------------------------------------------------
// Load cell peak capture
// Scales load cell samples to force and captures the peak of a measurement.
// ----------------------------------------------------------------------------
// Path: each item goes through the tare stage, the gain stage and the result register.
// Throughput: one item per cycle unless result.ready is low; gain multiply sets cycle time.
// Reset: rst_n clears all valid flags, the phase (idle), the peak and count
// registers, and loads the configuration registers with their defaults.
// The block accepts items right after reset; there is no clearing pass.
// ----------------------------------------------------------------------------
`include "load_cell_peak_capture_macros.svh"

module load_cell_peak_capture
    import lcpc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    lcpc_item_if.sink     item,
    lcpc_result_if.source result,
    lcpc_cfg_if.sink      cfg
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes are always taken, as cfg.ready is tied high;
    // an index beyond the register list is accepted and dropped.
    // ------------------------------------------------------------------
    logic [FORCE_BITS-1:0] tare_offset_reg;
    logic [GAIN_BITS-1:0]  gain_q24_reg;
    logic [THR_BITS-1:0]   start_threshold_reg;
    logic [THR_BITS-1:0]   stop_threshold_reg;
    logic [COUNT_BITS-1:0] max_samples_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tare_offset_reg     <= TARE_RESET;
            gain_q24_reg        <= GAIN_RESET;
            start_threshold_reg <= START_RESET;
            stop_threshold_reg  <= STOP_RESET;
            max_samples_reg     <= MAX_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (lcpc_reg_t'(cfg.index))
                REG_TARE_OFFSET:     tare_offset_reg     <= cfg.data[FORCE_BITS-1:0];
                REG_GAIN_Q24:        gain_q24_reg        <= cfg.data[GAIN_BITS-1:0];
                REG_START_THRESHOLD: start_threshold_reg <= cfg.data[THR_BITS-1:0];
                REG_STOP_THRESHOLD:  stop_threshold_reg  <= cfg.data[THR_BITS-1:0];
                REG_MAX_SAMPLES:     max_samples_reg     <= cfg.data[COUNT_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Front end: tare correction and gain scaling in two stages.
    // ------------------------------------------------------------------
    lcpc_scale_cfg_t scale_cfg;
    logic            scaled_valid;
    logic            scaled_ready;
    lcpc_scaled_t    scaled_item;

    assign scale_cfg.tare_offset = tare_offset_reg;
    assign scale_cfg.gain_q24    = gain_q24_reg;

    lcpc_scaler u_scaler (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (scale_cfg),
        .in_valid  (item.valid),
        .in_ready  (item.ready),
        .in_mode   (item.mode),
        .in_raw    (item.raw_sample),
        .out_valid (scaled_valid),
        .out_ready (scaled_ready),
        .out_item  (scaled_item)
    );

    // ------------------------------------------------------------------
    // Measurement state. It changes only when a scaled item moves into
    // the result register, so items update it strictly in order and the
    // next item always sees the state left by the one before it.
    // ------------------------------------------------------------------
    lcpc_phase_t           phase_reg;
    lcpc_phase_t           phase_next;
    logic [FORCE_BITS-1:0] running_peak_reg;
    logic [FORCE_BITS-1:0] running_peak_next;
    logic [FORCE_BITS-1:0] last_peak_reg;
    logic [FORCE_BITS-1:0] last_peak_next;
    logic [COUNT_BITS-1:0] capture_count_reg;
    logic [COUNT_BITS-1:0] capture_count_next;
    logic                  done_next;
    logic                  aborted_next;

    logic                  res_valid_reg;
    lcpc_result_t          res_reg;
    lcpc_result_t          res_next;
    logic                  res_load;

    logic [FORCE_BITS-1:0] start_level;
    logic [FORCE_BITS-1:0] stop_level;
    logic [COUNT_BITS-1:0] count_inc;
    logic [FORCE_BITS-1:0] peak_upd;

    // The result register is a full output stage: it reloads whenever it is
    // empty or its current result is transferred in the same cycle.
    assign res_load     = scaled_valid && (!res_valid_reg || result.ready);
    assign scaled_ready = !res_valid_reg || result.ready;

    // Thresholds are whole grams; force is in 1/256 gram.
    assign start_level = {start_threshold_reg, THR_SHIFT'(0)};
    assign stop_level  = {stop_threshold_reg, THR_SHIFT'(0)};
    assign count_inc   = capture_count_reg + COUNT_BITS'(1);
    assign peak_upd    = (scaled_item.force_q8 > running_peak_reg) ? scaled_item.force_q8
                                                                   : running_peak_reg;

    always_comb
    begin
        phase_next         = phase_reg;
        running_peak_next  = running_peak_reg;
        last_peak_next     = last_peak_reg;
        capture_count_next = capture_count_reg;
        done_next          = 1'b0;
        aborted_next       = 1'b0;

        unique case (lcpc_mode_t'(scaled_item.mode))
            MODE_ARM:
            begin
                // Arming restarts even an active measurement.
                phase_next         = PH_WAIT;
                running_peak_next  = '0;
                capture_count_next = '0;
            end
            MODE_ABORT:
            begin
                if (phase_reg != PH_IDLE)
                begin
                    phase_next   = PH_IDLE;
                    aborted_next = 1'b1;
                end
            end
            MODE_SAMPLE:
            begin
                unique case (phase_reg)
                    PH_WAIT:
                    begin
                        // The crossing sample only opens the capture.
                        if (scaled_item.force_q8 >= start_level)
                        begin
                            phase_next = PH_CAPT;
                        end
                    end
                    PH_CAPT:
                    begin
                        capture_count_next = count_inc;
                        running_peak_next  = peak_upd;
                        // A limit of zero ends the capture after one sample.
                        if ((scaled_item.force_q8 < stop_level) ||
                            (count_inc >= max_samples_reg))
                        begin
                            phase_next     = PH_IDLE;
                            last_peak_next = peak_upd;
                            done_next      = 1'b1;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase

        res_next.force_q8     = scaled_item.force_q8;
        res_next.phase        = phase_next;
        res_next.done_res     = done_next;
        res_next.aborted      = aborted_next;
        res_next.peak_q8      = last_peak_next;
        res_next.sample_count = capture_count_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            running_peak_reg  <= '0;
            last_peak_reg     <= '0;
            capture_count_reg <= '0;
            res_valid_reg     <= 1'b0;
        end
        else
        begin
            if (res_load)
            begin
                phase_reg         <= phase_next;
                running_peak_reg  <= running_peak_next;
                last_peak_reg     <= last_peak_next;
                capture_count_reg <= capture_count_next;
            end
            if (scaled_ready)
            begin
                res_valid_reg <= scaled_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign result.valid        = res_valid_reg;
    assign result.force_q8     = res_reg.force_q8;
    assign result.phase        = res_reg.phase;
    assign result.done_res     = res_reg.done_res;
    assign result.aborted      = res_reg.aborted;
    assign result.peak_q8      = res_reg.peak_q8;
    assign result.sample_count = res_reg.sample_count;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // The latched peak moves only with a result that ends a capture.
    `LCPC_ASSERT(a_peak_only_on_done, clk, rst_n, $stable(last_peak_reg) || (res_valid_reg && res_reg.done_res))
    // A completed or aborted measurement always reports the idle phase.
    `LCPC_ASSERT(a_end_is_idle, clk, rst_n, !(res_valid_reg && (res_reg.done_res || res_reg.aborted)) || (res_reg.phase == PH_IDLE))
    // A normal end and an abort never come from the same item.
    `LCPC_ASSERT(a_done_abort_excl, clk, rst_n, !(res_valid_reg && res_reg.done_res && res_reg.aborted))
    // A taken scaled item shows its state change in the next cycle.
    `LCPC_ASSERT_NEXT(a_state_follows, clk, rst_n, res_load, (phase_reg == res_reg.phase) && (capture_count_reg == res_reg.sample_count))

endmodule
